>>> rtl/core/rse_pkg.sv
// ----------------------------------------------------------------------------
// rse_pkg: shared types and constants for the record sort engine
// Record layout, operation codes, result status codes and control structs.
// ----------------------------------------------------------------------------
package rse_pkg;

  localparam int unsigned DEF_CAPACITY = 64;
  localparam int unsigned REC_W        = 59;

  typedef enum logic [2:0] {
    OP_APPEND  = 3'd0,
    OP_DISPLAY = 3'd1,
    OP_SORT_ID = 3'd2,
    OP_SORT_PR = 3'd3,
    OP_SORT_RT = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_REC   = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [2:0]  rating;
    logic [23:0] price;
    logic [15:0] id;
  } rec_t;

  // datapath commands from the controller
  typedef struct packed {
    logic       ld_a;     // capture RAM read data into reg A
    logic       ld_b;     // capture RAM read data into reg B
    logic       ld_in;    // capture input record into reg A
    logic       wr_a;     // write reg A to memory
    logic       wr_b;     // write reg B to memory
  } dp_cmd_t;

endpackage

>>> rtl/core/rse_ram.sv
// ----------------------------------------------------------------------------
// rse_ram: generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module rse_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/rse_datapath.sv
// ----------------------------------------------------------------------------
// rse_datapath: record store and working registers
// Holds the record RAM and two record registers A and B used by all sorts.
// ----------------------------------------------------------------------------
module rse_datapath
  import rse_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  dp_cmd_t                     cmd,
  input  logic [$clog2(CAPACITY)-1:0] addr,
  input  rec_t                        in_rec,
  output rec_t                        rd_rec,
  output rec_t                        reg_a
);

  rec_t reg_b;
  rec_t wdata;
  logic [REC_W-1:0] rdata;

  assign wdata  = cmd.wr_b ? reg_b : reg_a;
  assign rd_rec = rec_t'(rdata);

  rse_ram #(.WIDTH(REC_W), .DEPTH(CAPACITY)) u_ram (
    .clk  (clk),
    .we   (cmd.wr_a | cmd.wr_b),
    .addr (addr),
    .wdata(wdata),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      reg_a <= in_rec;
    end else if (cmd.ld_a) begin
      reg_a <= rec_t'(rdata);
    end
    if (cmd.ld_b) begin
      reg_b <= rec_t'(rdata);
    end
  end

endmodule

>>> rtl/core/rse_ctrl.sv
// ----------------------------------------------------------------------------
// rse_ctrl: sequencer for append, sorts and emit
// Walks the memory one access per cycle for bubble, selection and insertion
// sort, then streams the records out.
// ----------------------------------------------------------------------------
module rse_ctrl
  import rse_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  in_op,
  output dp_cmd_t                     cmd,
  output logic [$clog2(CAPACITY)-1:0] addr,
  input  rec_t                        rd_rec,
  input  rec_t                        reg_a,
  output logic                        o_valid,
  input  logic                        o_ready,
  output logic [1:0]                  o_status,
  output rec_t                        o_rec,
  output logic                        o_last
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [21:0] {
    S_IDLE  = 22'b00_0000_0000_0000_0000_0001,
    S_APWR  = 22'b00_0000_0000_0000_0000_0010, // append: write A at count
    S_BRD0  = 22'b00_0000_0000_0000_0000_0100, // bubble: read k
    S_BRD1  = 22'b00_0000_0000_0000_0000_1000, // bubble: A <= [k], read k+1
    S_BCMP  = 22'b00_0000_0000_0000_0001_0000, // B <= [k+1], compare
    S_BSWP  = 22'b00_0000_0000_0000_0010_0000, // write B at k
    S_BWR2  = 22'b00_0000_0000_0000_0100_0000, // write A at k+1
    S_SRD   = 22'b00_0000_0000_0000_1000_0000, // selection: read pos
    S_SLDA  = 22'b00_0000_0000_0001_0000_0000, // A <= [pos], read first scan slot
    S_SCMP  = 22'b00_0000_0000_0010_0000_0000, // one compare per cycle
    S_SSW0  = 22'b00_0000_0000_0100_0000_0000, // read pos again
    S_SSW1  = 22'b00_0000_0000_1000_0000_0000, // B <= [pos], write best to pos
    S_SSW2  = 22'b00_0000_0001_0000_0000_0000, // write old pos to best
    S_IRD   = 22'b00_0000_0010_0000_0000_0000, // insertion: read held
    S_ILD   = 22'b00_0000_0100_0000_0000_0000, // A <= held, read hole-1
    S_ICMP  = 22'b00_0000_1000_0000_0000_0000,
    S_ISH   = 22'b00_0001_0000_0000_0000_0000, // shift [hole-1] up
    S_IHRD  = 22'b00_0010_0000_0000_0000_0000, // read hole-1
    S_IWR   = 22'b00_0100_0000_0000_0000_0000, // held into slot 0
    S_EMRD  = 22'b00_1000_0000_0000_0000_0000, // emit: read k
    S_EMOUT = 22'b01_0000_0000_0000_0000_0000,
    S_EMWT  = 22'b10_0000_0000_0000_0000_0000
  } state_t;

  state_t        state;
  logic [CW-1:0] count;
  logic [CW-1:0] n;       // active length for passes
  logic [CW-1:0] i;       // outer index
  logic [CW-1:0] k;       // inner index
  logic [CW-1:0] best;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] k_dec;
  logic [CW-1:0] i_inc;
  logic          bub_gt;
  logic          sel_lt;
  logic          ins_lt;
  logic          bub_pass_end;
  logic          last_pass;

  assign k_inc        = k + CW'(1);
  assign k_dec        = k - CW'(1);
  assign i_inc        = i + CW'(1);
  assign bub_gt       = reg_a.id > rd_rec.id;
  assign sel_lt       = rd_rec.price < reg_a.price;
  assign ins_lt       = rd_rec.rating < reg_a.rating;
  assign bub_pass_end = (k + CW'(2)) >= (n - i);
  assign last_pass    = (i + CW'(2)) >= n;

  always_comb begin
    cmd  = '0;
    addr = k[AW-1:0];
    case (state)
      S_IDLE: begin
        cmd.ld_in = in_valid && in_ready && (in_op == OP_APPEND) &&
                    (count != CW'(CAPACITY));
      end
      S_APWR: begin
        cmd.wr_a = 1'b1;
        addr     = count[AW-1:0];
      end
      S_BRD1: begin
        cmd.ld_a = 1'b1;
        addr     = k_inc[AW-1:0];
      end
      S_BCMP: cmd.ld_b = 1'b1;
      S_BSWP: cmd.wr_b = 1'b1;
      S_BWR2: begin
        cmd.wr_a = 1'b1;
        addr     = k_inc[AW-1:0];
      end
      S_SRD: addr = i[AW-1:0];
      S_SLDA: cmd.ld_a = 1'b1;
      S_SCMP: begin
        // a strictly smaller price becomes the new best held in A
        cmd.ld_a = sel_lt;
        addr     = k_inc[AW-1:0];
      end
      S_SSW0: addr = i[AW-1:0];
      S_SSW1: begin
        cmd.ld_b = 1'b1;
        cmd.wr_a = 1'b1;
        addr     = i[AW-1:0];
      end
      S_SSW2: begin
        cmd.wr_b = 1'b1;
        addr     = best[AW-1:0];
      end
      S_IRD: addr = i[AW-1:0];
      S_ILD: begin
        cmd.ld_a = 1'b1;
        addr     = k_dec[AW-1:0];
      end
      S_ICMP: begin
        cmd.ld_b = ins_lt;
        cmd.wr_a = !ins_lt;
      end
      S_ISH: cmd.wr_b = 1'b1;
      S_IHRD: addr = k_dec[AW-1:0];
      S_IWR: cmd.wr_a = 1'b1;
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !o_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && o_ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            n <= count;
            k <= '0;
            i <= (in_op == OP_SORT_RT) ? CW'(1) : '0;
            case (in_op)
              OP_APPEND: begin
                if (count == CW'(CAPACITY)) begin
                  o_valid  <= 1'b1;
                  o_status <= ST_FULL;
                  o_rec    <= '0;
                  o_last   <= 1'b1;
                end else begin
                  state <= S_APWR;
                end
              end
              OP_DISPLAY, OP_SORT_ID, OP_SORT_PR, OP_SORT_RT: begin
                if (count == '0) begin
                  o_valid  <= 1'b1;
                  o_status <= ST_EMPTY;
                  o_rec    <= '0;
                  o_last   <= 1'b1;
                end else if (count == CW'(1) || in_op == OP_DISPLAY) begin
                  state <= S_EMRD;
                end else if (in_op == OP_SORT_ID) begin
                  state <= S_BRD0;
                end else if (in_op == OP_SORT_PR) begin
                  state <= S_SRD;
                end else begin
                  state <= S_IRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_APWR: begin
          count <= count + CW'(1);
          state <= S_IDLE;
        end
        // bubble: pass i over k = 0 .. n-2-i
        S_BRD0: state <= S_BRD1;
        S_BRD1: state <= S_BCMP;
        S_BCMP, S_BWR2: begin
          if (state == S_BCMP && bub_gt) begin
            state <= S_BSWP;
          end else if (bub_pass_end) begin
            k     <= '0;
            i     <= i_inc;
            state <= last_pass ? S_EMRD : S_BRD0;
          end else begin
            k     <= k_inc;
            state <= S_BRD0;
          end
        end
        S_BSWP: state <= S_BWR2;
        // selection: A holds the best record, scan k = i+1 .. n-1
        S_SRD: begin
          k     <= i_inc;
          best  <= i;
          state <= S_SLDA;
        end
        S_SLDA: state <= S_SCMP;
        S_SCMP: begin
          if (sel_lt) begin
            best <= k;
          end
          if (k_inc >= n) begin
            state <= S_SSW0;
          end else begin
            k <= k_inc;
          end
        end
        S_SSW0: state <= S_SSW1;
        S_SSW1: state <= S_SSW2;
        S_SSW2: begin
          i <= i_inc;
          if (last_pass) begin
            k     <= '0;
            state <= S_EMRD;
          end else begin
            state <= S_SRD;
          end
        end
        // insertion: A = held, hole k
        S_IRD: begin
          k     <= i;
          state <= S_ILD;
        end
        S_ILD: state <= S_ICMP;
        S_ICMP, S_IWR: begin
          if (state == S_ICMP && ins_lt) begin
            state <= S_ISH;
          end else if (i_inc < n) begin
            i     <= i_inc;
            state <= S_IRD;
          end else begin
            k     <= '0;
            state <= S_EMRD;
          end
        end
        S_ISH: begin
          k     <= k_dec;
          state <= (k_dec == '0) ? S_IWR : S_IHRD;
        end
        S_IHRD: state <= S_ICMP;
        S_EMRD: state <= S_EMOUT;
        S_EMOUT: begin
          o_valid  <= 1'b1;
          o_status <= ST_REC;
          o_rec    <= rd_rec;
          o_last   <= (k_inc == n);
          state    <= S_EMWT;
        end
        S_EMWT: begin
          if (o_ready) begin
            if (k_inc == n) begin
              state <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_EMRD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  property p_full_last;
    @(posedge clk) disable iff (rst) (o_valid && o_status == ST_FULL) |-> o_last;
  endproperty
  a_full_last: assert property (p_full_last) else $error("full result not last");

  property p_count_max;
    @(posedge clk) disable iff (rst) count <= CW'(CAPACITY);
  endproperty
  a_count_max: assert property (p_count_max) else $error("count overflow");

  property p_busy_no_ready;
    @(posedge clk) disable iff (rst) (state != S_IDLE) |-> !in_ready;
  endproperty
  a_busy_no_ready: assert property (p_busy_no_ready) else $error("ready while busy");

  property p_out_hold;
    @(posedge clk) disable iff (rst)
      (o_valid && !o_ready) |=> (o_valid && $stable(o_rec) && $stable(o_last));
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result beat changed while held");

endmodule

>>> rtl/core/record_sort_engine.sv
// ----------------------------------------------------------------------------
// record_sort_engine: record store with bubble, selection and insertion sort
// Appends records, sorts the store in place and streams it out.
// ----------------------------------------------------------------------------
// Append loads the record into A on accept and writes it at the count in S_APWR; a
// full or empty result beat is valid in the cycle after accept. Bubble sort swaps
// pairs by id, selection sort swaps in the lowest price, insertion sort shifts up.
// Emit holds each record until m_tready; next beat is taken after the last result.
// Reset clears the record count and the controller; the store keeps old data.
module record_sort_engine
  import rse_pkg::*;
#(
  parameter int unsigned CAPACITY = DEF_CAPACITY
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // rec_id, rec_price, rec_rating, rec_tag
  input  logic [2:0]  s_tuser,  // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // out_id, out_price, out_rating, out_tag
  output logic [1:0]  m_tuser,  // status
  output logic        m_tlast
);

  dp_cmd_t cmd;
  logic [$clog2(CAPACITY)-1:0] addr;
  rec_t in_rec, rd_rec, reg_a, o_rec;

  assign in_rec  = rec_t'(s_tdata[REC_W-1:0]);
  assign m_tdata = {5'b00000, o_rec};

  rse_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_op   (s_tuser),
    .cmd     (cmd),
    .addr    (addr),
    .rd_rec  (rd_rec),
    .reg_a   (reg_a),
    .o_valid (m_tvalid),
    .o_ready (m_tready),
    .o_status(m_tuser),
    .o_rec   (o_rec),
    .o_last  (m_tlast)
  );

  rse_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk   (clk),
    .cmd   (cmd),
    .addr  (addr),
    .in_rec(in_rec),
    .rd_rec(rd_rec),
    .reg_a (reg_a)
  );

endmodule
